// ===== rtl/hlg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hlg_pkg;

  localparam int HLG_MAX_ITEMS   = 65536;
  localparam int HLG_QUEUE_DEPTH = 2;
  localparam int SUM_W           = 64;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_DELTA    = 2'd0;
  localparam logic [1:0] REG_UPSTREAM = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;

  localparam logic [30:0]        DELTA_RESET    = 31'd65536;
  localparam logic signed [31:0] UPSTREAM_RESET = 32'sd65536;
  localparam logic [16:0]        SCALE_RESET    = 17'd65536;

  typedef struct packed {
    logic [30:0]        delta;
    logic signed [31:0] upstream;
    logic [16:0]        scale;
  } hlg_cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic               last;
    logic               in_band;
    logic [30:0]        mul_x;
    logic [31:0]        mul_y;
    logic signed [31:0] gd;
  } hlg_task_t;

endpackage
`default_nettype wire

// ===== rtl/hlg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hlg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pred_value;
  logic signed [31:0] target_value;
  logic               last_item;

  modport source (output valid, pred_value, target_value, last_item, input ready);
  modport sink (input valid, pred_value, target_value, last_item, output ready);
endinterface

interface hlg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] grad_term;
  logic               loss_valid;
  logic signed [31:0] mean_loss;

  modport source (output valid, grad_term, loss_valid, mean_loss, input ready);
  modport sink (input valid, grad_term, loss_valid, mean_loss, output ready);
endinterface
`default_nettype wire

// ===== rtl/hlg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlg_front import hlg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  hlg_cfg_t  cfg,
  hlg_in_if.sink    sample,
  output logic      push,
  output hlg_task_t wdata,
  input  logic      full
);

  logic               hold_valid;
  logic signed [31:0] hold_d;
  logic               hold_last;

  logic [31:0] mag;
  logic [31:0] delta_ext;
  logic [31:0] neg_delta;
  logic [31:0] half_delta;
  logic        in_band;

  assign push         = hold_valid && !full;
  assign sample.ready = !hold_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  // The residual wraps to 32 bits.
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      hold_d    <= sample.pred_value - sample.target_value;
      hold_last <= sample.last_item;
    end
  end

  // The magnitude is unsigned, so a residual of -2^31 keeps its true size.
  always_comb begin
    mag        = hold_d[31] ? (~$unsigned(hold_d) + 32'd1) : $unsigned(hold_d);
    delta_ext  = {1'b0, cfg.delta};
    neg_delta  = ~delta_ext + 32'd1;
    half_delta = {2'b00, cfg.delta[30:1]};
    in_band    = mag < delta_ext;

    wdata.last    = hold_last;
    wdata.in_band = in_band;
    wdata.mul_x   = in_band ? mag[30:0] : cfg.delta;
    wdata.mul_y   = in_band ? mag : (mag - half_delta);
    if (in_band) begin
      wdata.gd = hold_d;
    end else if (hold_d[31]) begin
      wdata.gd = $signed(neg_delta);
    end else begin
      wdata.gd = $signed(delta_ext);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hlg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlg_queue import hlg_pkg::*; #(
  parameter int DEPTH = HLG_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hlg_task_t wdata,
  output logic      full,
  input  logic      pop,
  output hlg_task_t rdata,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hlg_task_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = fill == CNT_W'(DEPTH);
  assign empty   = fill == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hlg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlg_div import hlg_pkg::*; #(
  parameter int CNT_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    rem_sh  = {rem, quotient[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    ge      = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hlg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlg_back import hlg_pkg::*; #(
  parameter int MAX_ITEMS = HLG_MAX_ITEMS
) (
  input  logic      clk,
  input  logic      rst,
  input  hlg_cfg_t  cfg,
  input  logic      q_empty,
  input  hlg_task_t q_data,
  output logic      q_pop,
  hlg_out_if.source result
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ACC   = 6'b000010,
    ST_SCALE = 6'b000100,
    ST_FIN   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } back_state_t;

  back_state_t        state;
  logic [62:0]        loss_prod;
  logic signed [63:0] g1_prod;
  logic signed [31:0] g1;
  logic signed [49:0] g2_prod;
  logic signed [31:0] grad_r;
  logic signed [31:0] mean_r;
  logic               inside_r;
  logic               last_r;
  logic [SUM_W-1:0]   loss_sum;
  logic [CNT_W-1:0]   count;
  logic               out_valid;

  logic [46:0]        term;
  logic [SUM_W:0]     sum_ext;
  logic signed [31:0] g1_sat;
  logic signed [31:0] g2_sat;
  logic signed [17:0] scale_s;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   quotient;
  logic               out_load;

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign div_start = (state == ST_FIN) && last_r;
  assign out_load  = (state == ST_OUT) && (!out_valid || result.ready);
  assign scale_s   = $signed({1'b0, cfg.scale});

  always_comb begin
    // Inside the band the extra halving folds into the shift.
    term    = inside_r ? {1'b0, loss_prod[62:17]} : loss_prod[62:16];
    sum_ext = {1'b0, loss_sum} + {{(SUM_W - 46){1'b0}}, term};
    if (g1_prod[63:47] == {17{g1_prod[47]}}) begin
      g1_sat = g1_prod[47:16];
    end else begin
      g1_sat = g1_prod[63] ? S32_MIN : S32_MAX;
    end
    if (g2_prod[49:47] == {3{g2_prod[47]}}) begin
      g2_sat = g2_prod[47:16];
    end else begin
      g2_sat = g2_prod[49] ? S32_MIN : S32_MAX;
    end
  end

  hlg_div #(
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(loss_sum),
    .divisor (count),
    .done    (div_done),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      loss_sum <= '0;
      count    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          loss_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          if (count < CNT_W'(MAX_ITEMS)) begin
            count <= count + 1'b1;
          end
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (last_r) begin
            // The divider has taken its copies at this edge.
            loss_sum <= '0;
            count    <= '0;
            state    <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      loss_prod <= q_data.mul_x * q_data.mul_y;
      g1_prod   <= q_data.gd * cfg.upstream;
      inside_r  <= q_data.in_band;
      last_r    <= q_data.last;
    end
    if (state == ST_ACC) begin
      g1 <= g1_sat;
    end
    if (state == ST_SCALE) begin
      g2_prod <= g1 * scale_s;
    end
    if (state == ST_FIN) begin
      grad_r <= g2_sat;
      mean_r <= '0;
    end
    if ((state == ST_DIV) && div_done) begin
      mean_r <= (quotient[SUM_W-1:31] != '0) ? S32_MAX : $signed({1'b0, quotient[30:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.grad_term  <= grad_r;
      result.loss_valid <= last_r;
      result.mean_loss  <= mean_r;
    end
  end

  assign result.valid = out_valid;

endmodule
`default_nettype wire

// ===== rtl/huber_loss_with_gradient_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The back-end sequencer works on one item at a time (two multiply steps, accumulate,
// saturate, output load) and pops the next item only after the output load; the last
// item of a run also waits for the 64-step shift-subtract divider that forms the mean.
// Reset (synchronous, active high) empties the queue, clears the running sum and
// count, and returns the registers to delta 1.0, upstream gradient 1.0, scale 1.0.
module huber_loss_with_gradient_unit import hlg_pkg::*; #(
  parameter int MAX_ITEMS   = HLG_MAX_ITEMS,
  parameter int QUEUE_DEPTH = HLG_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  hlg_in_if.sink      sample,
  hlg_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hlg_cfg_t  cfg;
  logic      cfg_wr;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  hlg_task_t q_wdata;
  hlg_task_t q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delta    <= DELTA_RESET;
      cfg.upstream <= UPSTREAM_RESET;
      cfg.scale    <= SCALE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DELTA:    cfg.delta    <= pwdata[30:0];
        REG_UPSTREAM: cfg.upstream <= $signed(pwdata);
        REG_SCALE:    cfg.scale    <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DELTA:    prdata = {1'b0, cfg.delta};
      REG_UPSTREAM: prdata = $unsigned(cfg.upstream);
      REG_SCALE:    prdata = {15'd0, cfg.scale};
      default:      prdata = '0;
    endcase
  end

  hlg_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .sample(sample),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full)
  );

  hlg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  hlg_back #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_empty(q_empty),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .result (result)
  );

endmodule
`default_nettype wire

// ===== rtl/hlg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] grad_term,
  input logic        loss_valid,
  input logic [31:0] mean_loss,
  input logic        pready
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(grad_term) && $stable(loss_valid)
      && $stable(mean_loss))
    else $error("result changed while stalled");

  // Only the last item of a run carries a mean; the others carry zero.
  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !loss_valid |-> mean_loss == 32'd0)
    else $error("mean_loss nonzero on an item that is not last");

  // The mean of nonnegative loss terms saturates high and is never negative.
  a_mean_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && loss_valid |-> !mean_loss[31])
    else $error("mean_loss negative");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind huber_loss_with_gradient_unit hlg_checker u_hlg_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .grad_term (result.grad_term),
  .loss_valid(result.loss_valid),
  .mean_loss (result.mean_loss),
  .pready    (pready)
);
`default_nettype wire

// ===== tb/hlg_loss_checker.sv =====
`timescale 1ns / 1ps
module hlg_loss_checker import hlg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hlg_in_if           samples,
  hlg_out_if          results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          open_results
);

  typedef struct packed {
    logic signed [31:0] grad_term;
    logic               loss_valid;
    logic signed [31:0] mean_loss;
  } huber_result_t;

  huber_result_t expected_q[$];
  hlg_cfg_t      cfg;
  logic [63:0]   loss_acc;
  int unsigned   elem_count;

  // Q16.16 multiply: full product, floor shift, then clamp to 32 bits.
  function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
    logic signed [63:0] scaled;
    scaled = (x * y) >>> 16;
    if (scaled > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (scaled < -64'sd2147483648) return 32'sh80000000;
    return scaled[31:0];
  endfunction

  task automatic predict_huber(input logic signed [31:0] p, input logic signed [31:0] t,
                               input logic last);
    logic signed [31:0] d;
    logic [31:0]        mag;
    logic [63:0]        mag64;
    logic [63:0]        dl64;
    logic [63:0]        term;
    logic [63:0]        quot;
    logic signed [63:0] gd;
    huber_result_t      r;
    d = p - t;
    // The magnitude is unsigned, so a residual of -2^31 keeps its true size.
    mag = d[31] ? (~d + 32'd1) : d;
    mag64 = {32'd0, mag};
    dl64 = {33'd0, cfg.delta};
    if (mag64 < dl64) begin
      term = (mag64 * mag64) >> 17;
      gd = d;
    end else begin
      term = (dl64 * (mag64 - (dl64 >> 1))) >> 16;
      gd = d[31] ? -$signed(dl64) : $signed(dl64);
    end
    if (loss_acc > (~64'd0 - term)) loss_acc = ~64'd0;
    else loss_acc = loss_acc + term;
    if (elem_count < HLG_MAX_ITEMS) elem_count++;
    r.grad_term = qmul_sat(qmul_sat(gd, cfg.upstream), $signed({47'd0, cfg.scale}));
    r.loss_valid = last;
    r.mean_loss = '0;
    if (last) begin
      quot = loss_acc / 64'(elem_count);
      r.mean_loss = (quot > 64'h7FFFFFFF) ? 32'h7FFFFFFF : quot[31:0];
      loss_acc = '0;
      elem_count = 0;
    end
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    huber_result_t want;
    if (rst) begin
      cfg.delta = DELTA_RESET;
      cfg.upstream = UPSTREAM_RESET;
      cfg.scale = SCALE_RESET;
      loss_acc = '0;
      elem_count = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DELTA:    cfg.delta = pwdata[30:0];
          REG_UPSTREAM: cfg.upstream = pwdata;
          REG_SCALE:    cfg.scale = pwdata[16:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        predict_huber(samples.pred_value, samples.target_value, samples.last_item);
      if (results.valid && results.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: grad_term %0d loss_valid %0b mean_loss %0d",
                 results.grad_term, results.loss_valid, results.mean_loss);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (results.grad_term !== want.grad_term) begin
            $error("grad_term: expected %0d, actual %0d", want.grad_term, results.grad_term);
            fail_count++;
          end
          if (results.loss_valid !== want.loss_valid) begin
            $error("loss_valid: expected %0b, actual %0b", want.loss_valid,
                   results.loss_valid);
            fail_count++;
          end
          if (results.mean_loss !== want.mean_loss) begin
            $error("mean_loss: expected %0d, actual %0d", want.mean_loss, results.mean_loss);
            fail_count++;
          end
        end
      end
    end
    open_results = expected_q.size();
  end

endmodule

// ===== tb/tb_huber_loss_with_gradient_unit.sv =====
`timescale 1ns / 1ps
module tb_huber_loss_with_gradient_unit;
  import hlg_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          open_results;
  int          cycle_count = 0;
  int          src_idle_pct;
  int          sink_stall_pct;
  logic [30:0] delta_now;

  hlg_in_if  sample_ch();
  hlg_out_if result_ch();

  huber_loss_with_gradient_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hlg_loss_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .samples      (sample_ch),
    .results      (result_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("huber_loss_with_gradient_unit regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 83; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 83; end
      default:       begin src_idle_pct = 13; sink_stall_pct = 13; end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_sample(input logic [31:0] p, input logic [31:0] t, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid = 1'b1;
    sample_ch.pred_value = p;
    sample_ch.target_value = t;
    sample_ch.last_item = last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    sample_ch.valid = 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_cfg(input logic [30:0] delta, input logic [31:0] upstream,
                           input logic [16:0] scale);
    wait_drained();
    write_reg(REG_DELTA, {1'b0, delta});
    write_reg(REG_UPSTREAM, upstream);
    write_reg(REG_SCALE, {15'd0, scale});
    delta_now = delta;
  endtask

  task automatic send_random_item(input int last_pct);
    logic signed [31:0] t;
    logic signed [31:0] off;
    int                 kind;
    t = $urandom;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      // Residuals right around the transition point.
      off = $signed({1'b0, delta_now}) + ($signed($urandom_range(0, 8)) - 32'sd4);
      if ($urandom_range(0, 1)) off = -off;
    end else if (kind <= 5) begin
      off = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    end else if (kind <= 7) begin
      off = $urandom;
    end else if (kind == 8) begin
      t = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      off = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      off = '0;
    end
    send_sample(t + off, t, $urandom_range(0, 99) < last_pct);
  endtask

  task automatic pick_config(input int phase);
    logic [30:0] delta;
    logic [31:0] upstream;
    logic [16:0] scale;
    delta = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 22));
    upstream = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18);
    if ($urandom_range(0, 1)) upstream = -upstream;
    scale = $urandom_range(0, 65536);
    case (phase)
      1: begin delta = '0; scale = '0; end
      2: begin delta = 31'h7FFF_FFFF; upstream = 32'h7FFF_FFFF; scale = 17'd65536; end
      3: begin upstream = 32'h8000_0000; scale = 17'd65536; end
      5: begin delta = DELTA_RESET; upstream = UPSTREAM_RESET; scale = SCALE_RESET; end
      default: ;
    endcase
    write_cfg(delta, upstream, scale);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.pred_value = '0;
    sample_ch.target_value = '0;
    sample_ch.last_item = 1'b0;
    delta_now = DELTA_RESET;
    set_idling(IDLE_NONE);
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed items under the reset settings first.
    set_idling(IDLE_BOTH);
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h0000_0000, 32'h8000_0001, 1'b0);
    send_sample(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h0000_FFFF, 32'h0000_0000, 1'b0);
    send_sample(32'h0000_0000, 32'h0001_0000, 1'b0);
    send_sample(32'h0000_8000, 32'h0001_0000, 1'b1);

    // A zero delta sends everything down the linear branch.
    write_cfg('0, 32'h8000_0000, 17'd65536);
    send_sample(32'd5, 32'd5, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_sample(32'd123456, -32'sd98765, 1'b1);

    // Largest settings: saturated gradients and a mean that clips.
    write_cfg(31'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd65536);
    send_sample(32'h8000_0000, 32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFE, 32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

    write_cfg(31'd65536, 32'h8000_0000, 17'd0);
    send_sample(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    write_cfg(31'd3, 32'h8000_0000, 17'd1);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      pick_config(phase);
      set_idling(idle_mode_t'(phase % 4));
      for (int n = 0; n < 110; n++) send_random_item(12);
    end
    send_sample($urandom, $urandom, 1'b1);

    sample_ch.valid = 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0) begin
      $display("huber_loss_with_gradient_unit regression: pass");
    end else begin
      $display("huber_loss_with_gradient_unit regression: fail");
    end
    $finish;
  end

endmodule
